/* rtl/core/obstacle_track_merge_table_assert.svh */
`ifndef OBSTACLE_TRACK_MERGE_TABLE_ASSERT_SVH
`define OBSTACLE_TRACK_MERGE_TABLE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define OTMT_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("otmt assertion failed");

// Next-cycle implication, checked out of reset
`define OTMT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("otmt assertion failed");

`endif

/* rtl/core/otmt_pkg.sv */
package otmt_pkg;

    localparam int TABLE_DEPTH_DEF = 32;

    // register indexes
    localparam logic [7:0] REG_SOURCE_MASK   = 8'd0;
    localparam logic [7:0] REG_FILTER_ENABLE = 8'd1;
    localparam logic [7:0] REG_MERGE_ENABLE  = 8'd2;
    localparam logic [7:0] REG_EXPIRE_ENABLE = 8'd3;
    localparam logic [7:0] REG_MAX_AGE_MS    = 8'd4;
    localparam logic [7:0] REG_TOL_SAMPLE    = 8'd5;
    localparam logic [7:0] REG_TOL_RIVAL     = 8'd6;
    localparam logic [7:0] REG_BLEND_BETA    = 8'd7;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic               obstacle_kind;
        logic [1:0]         source_id;
        logic [31:0]        stamp_ms;
    } obs_in_t;

    typedef struct packed {
        logic               accepted;
        logic signed [15:0] stored_x;
        logic signed [15:0] stored_y;
        logic [4:0]         slot;
        logic [5:0]         merged_count;
        logic               overflow;
    } obs_out_t;

    // one table entry as held by a cell
    typedef struct packed {
        logic               valid;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               kind;
        logic [31:0]        stamp;
    } entry_t;

    // control from the sequencer to one cell
    typedef struct packed {
        logic shift_en;
        logic kill;
        logic wr_en;
    } cell_ctrl_t;

endpackage

/* rtl/core/obstacle_track_merge_table.sv */
// Obstacle track merge table.
// Input channel s_valid/s_ready/s_data carries one observation item; result
// channel m_valid/m_ready/m_data returns exactly one result item per input.
// Configuration writes arrive on cfg_valid/cfg_index/cfg_data (cfg_ready is
// always high); indexes beyond the register list are ignored.
// The table is a ring of TABLE_DEPTH cells. An accepted item rotates the
// ring once, one entry per cycle through a three-stage compare pipe (age and
// deltas, squared distance, match and selection); the blend products are
// then registered, and then the write loads the chosen cell and the output
// register. A dropped item skips the scan and goes straight to the write.
// One item is in work at a time, so a new item is taken only once the
// last one has been written.
// A finished result waits in the output register; the next item is taken
// meanwhile, and only its final write stalls while m_ready stays low.
// Reset (aresetn low, synchronous) clears every entry's valid bit and loads
// the register defaults; no clearing pass is needed.
module obstacle_track_merge_table #(
    parameter int TABLE_DEPTH = otmt_pkg::TABLE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  otmt_pkg::obs_in_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output otmt_pkg::obs_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    `include "obstacle_track_merge_table_assert.svh"

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_BLEND = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;

    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    // configuration registers
    logic [2:0]  source_mask_reg;
    logic        filter_enable_reg, merge_enable_reg, expire_enable_reg;
    logic [15:0] max_age_reg;
    logic [14:0] tol_sample_reg, tol_rival_reg;
    logic [8:0]  beta_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_mask_reg   <= 3'd0;
            filter_enable_reg <= 1'b0;
            merge_enable_reg  <= 1'b0;
            expire_enable_reg <= 1'b0;
            max_age_reg       <= 16'd1000;
            tol_sample_reg    <= 15'd410;
            tol_rival_reg     <= 15'd410;
            beta_reg          <= 9'd128;
        end else if (cfg_valid) begin
            case (cfg_index)
                otmt_pkg::REG_SOURCE_MASK:   source_mask_reg   <= cfg_data[2:0];
                otmt_pkg::REG_FILTER_ENABLE: filter_enable_reg <= cfg_data[0];
                otmt_pkg::REG_MERGE_ENABLE:  merge_enable_reg  <= cfg_data[0];
                otmt_pkg::REG_EXPIRE_ENABLE: expire_enable_reg <= cfg_data[0];
                otmt_pkg::REG_MAX_AGE_MS:    max_age_reg       <= cfg_data[15:0];
                otmt_pkg::REG_TOL_SAMPLE:    tol_sample_reg    <= cfg_data[14:0];
                otmt_pkg::REG_TOL_RIVAL:     tol_rival_reg     <= cfg_data[14:0];
                otmt_pkg::REG_BLEND_BETA:    beta_reg          <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // sequencer
    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] scan_reg, scan_next;
    otmt_pkg::obs_in_t item_reg;
    logic          drop_reg;
    logic [29:0]   tol2_reg;
    logic          s_fire, write_fire;

    logic src_ok;
    assign src_ok = (s_data.source_id != 2'd3) && source_mask_reg[s_data.source_id];

    // stage registers
    logic          p1_v, p2_v;
    logic [IW-1:0] p1_idx, p2_idx;
    logic          p1_live, p1_exp, p1_km, p2_live, p2_exp, p2_km;
    logic signed [16:0] p1_dx, p1_dy;
    logic [31:0]   p1_age, p2_age;
    logic signed [15:0] p1_ex, p1_ey, p2_ex, p2_ey;
    logic [34:0]   p2_d2;

    // accumulators
    logic              free_found_reg, has_new_reg;
    logic [IW-1:0]     free_idx_reg, worst_idx_reg;
    logic [31:0]       best_age_reg, worst_age_reg;
    logic signed [15:0] old_x_reg, old_y_reg;
    logic [CW-1:0]     mcount_reg;
    logic [TABLE_DEPTH-1:0] kill_reg;

    // blend products
    logic [24:0] bx_reg, ox_reg, by_reg, oy_reg;

    // output register
    logic              out_valid_reg;
    otmt_pkg::obs_out_t out_data_reg;

    // ring of cells
    otmt_pkg::entry_t cell_q [TABLE_DEPTH];
    otmt_pkg::entry_t wr_entry;
    logic [IW-1:0]    slot_idx;
    logic signed [15:0] fin_x, fin_y;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign write_fire = (state_reg == ST_WRITE) && (!out_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        scan_next  = scan_reg;
        case (state_reg)
            ST_IDLE: begin
                scan_next = '0;
                if (s_valid) begin
                    state_next = src_ok ? ST_SCAN : ST_WRITE;
                end
            end
            ST_SCAN: begin
                scan_next = scan_reg + 1'b1;
                if (scan_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (p2_v && (p2_idx == LAST_IDX)) begin
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND: state_next = ST_WRITE;
            ST_WRITE: begin
                if (write_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            scan_reg  <= '0;
        end else begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
        end
    end

    // latch the item and its squared tolerance
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= s_data;
            drop_reg <= !src_ok;
            tol2_reg <= s_data.obstacle_kind ? (30'(tol_rival_reg) * 30'(tol_rival_reg))
                                             : (30'(tol_sample_reg) * 30'(tol_sample_reg));
        end
    end

    // stage 1: age, expiry, deltas from the head cell
    logic [31:0] head_age;
    assign head_age = item_reg.stamp_ms - cell_q[0].stamp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v <= 1'b0;
        end else begin
            p1_v <= (state_reg == ST_SCAN);
        end
        p1_idx  <= scan_reg;
        p1_age  <= head_age;
        p1_exp  <= filter_enable_reg && expire_enable_reg && cell_q[0].valid
                   && (head_age > {16'd0, max_age_reg});
        p1_live <= cell_q[0].valid;
        p1_km   <= (cell_q[0].kind == item_reg.obstacle_kind);
        p1_dx   <= {item_reg.pos_x[15], item_reg.pos_x} - {cell_q[0].x[15], cell_q[0].x};
        p1_dy   <= {item_reg.pos_y[15], item_reg.pos_y} - {cell_q[0].y[15], cell_q[0].y};
        p1_ex   <= cell_q[0].x;
        p1_ey   <= cell_q[0].y;
    end

    // stage 2: squared distance
    logic signed [33:0] sqx, sqy;
    assign sqx = p1_dx * p1_dx;
    assign sqy = p1_dy * p1_dy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_v <= 1'b0;
        end else begin
            p2_v <= p1_v;
        end
        p2_idx  <= p1_idx;
        p2_age  <= p1_age;
        p2_exp  <= p1_exp;
        p2_live <= p1_live && !p1_exp;
        p2_km   <= p1_km;
        p2_ex   <= p1_ex;
        p2_ey   <= p1_ey;
        p2_d2   <= 35'(unsigned'(sqx)) + 35'(unsigned'(sqy));
    end

    // stage 3: match, newest match, free slot and oldest entry
    logic p2_match, p2_dead;
    assign p2_match = p2_live && p2_km && filter_enable_reg && merge_enable_reg
                      && (p2_d2 < {5'd0, tol2_reg});
    assign p2_dead  = !p2_live || p2_match;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            free_found_reg <= 1'b0;
            has_new_reg    <= 1'b0;
            mcount_reg     <= '0;
            kill_reg       <= '0;
        end else if (p2_v) begin
            if (p2_dead && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= p2_idx;
            end
            if (p2_match) begin
                mcount_reg <= mcount_reg + 1'b1;
                if (!has_new_reg || (p2_age < best_age_reg)) begin
                    has_new_reg  <= 1'b1;
                    best_age_reg <= p2_age;
                    old_x_reg    <= p2_ex;
                    old_y_reg    <= p2_ey;
                end
            end
            if ((p2_idx == '0) || (p2_age > worst_age_reg)) begin
                worst_age_reg <= p2_age;
                worst_idx_reg <= p2_idx;
            end
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (p2_idx == IW'(i) && (p2_exp || p2_match)) begin
                    kill_reg[i] <= 1'b1;
                end
            end
        end
    end

    // blend products, offset binary operands
    logic [8:0]  beta_sat, beta_inv;
    logic [15:0] nx_u, ny_u, ox_u, oy_u;
    assign beta_sat = (beta_reg > 9'd256) ? 9'd256 : beta_reg;
    assign beta_inv = 9'd256 - beta_sat;
    assign nx_u = {~item_reg.pos_x[15], item_reg.pos_x[14:0]};
    assign ny_u = {~item_reg.pos_y[15], item_reg.pos_y[14:0]};
    assign ox_u = {~old_x_reg[15], old_x_reg[14:0]};
    assign oy_u = {~old_y_reg[15], old_y_reg[14:0]};

    always_ff @(posedge aclk) begin
        if (state_reg == ST_BLEND) begin
            bx_reg <= 25'(beta_sat) * 25'(nx_u);
            by_reg <= 25'(beta_sat) * 25'(ny_u);
            ox_reg <= 25'(beta_inv) * 25'(ox_u);
            oy_reg <= 25'(beta_inv) * 25'(oy_u);
        end
    end

    logic [25:0] sum_x, sum_y;
    assign sum_x = 26'(bx_reg) + 26'(ox_reg) + 26'd128;
    assign sum_y = 26'(by_reg) + 26'(oy_reg) + 26'd128;
    assign fin_x = has_new_reg ? signed'({~sum_x[23], sum_x[22:8]}) : item_reg.pos_x;
    assign fin_y = has_new_reg ? signed'({~sum_y[23], sum_y[22:8]}) : item_reg.pos_y;
    assign slot_idx = free_found_reg ? free_idx_reg : worst_idx_reg;

    assign wr_entry = '{valid: 1'b1, x: fin_x, y: fin_y,
                        kind: item_reg.obstacle_kind, stamp: item_reg.stamp_ms};

    // result register
    logic [IW+4:0] slot_ext;
    assign slot_ext = (IW + 5)'(slot_idx);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (write_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (write_fire) begin
            if (drop_reg) begin
                out_data_reg <= '0;
            end else begin
                out_data_reg.accepted     <= 1'b1;
                out_data_reg.stored_x     <= fin_x;
                out_data_reg.stored_y     <= fin_y;
                out_data_reg.slot         <= slot_ext[4:0];
                out_data_reg.merged_count <= ((CW + 6)'(mcount_reg) > (CW + 6)'(63))
                                             ? 6'd63 : 6'(mcount_reg);
                out_data_reg.overflow     <= !free_found_reg;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // the ring
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        otmt_pkg::cell_ctrl_t ctrl;
        assign ctrl.shift_en = (state_reg == ST_SCAN);
        assign ctrl.kill     = write_fire && !drop_reg && kill_reg[g];
        assign ctrl.wr_en    = write_fire && !drop_reg && (slot_idx == IW'(g));

        otmt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .shift_in (cell_q[(g + 1) % TABLE_DEPTH]),
            .wr_data  (wr_entry),
            .q        (cell_q[g])
        );
    end

    // checks
    `OTMT_ASSERT_NOW(a_merge_means_accept, aclk, aresetn,
        m_valid && (m_data.merged_count != 6'd0), m_data.accepted && !m_data.overflow)
    `OTMT_ASSERT_NEXT(a_scan_wraps, aclk, aresetn,
        (state_reg == ST_SCAN) && (scan_reg == LAST_IDX), state_reg == ST_DRAIN)
    `OTMT_ASSERT_NOW(a_pipe_idle_outside_scan, aclk, aresetn,
        (state_reg == ST_IDLE) || (state_reg == ST_WRITE), !p1_v && !p2_v)
    `OTMT_ASSERT_NEXT(a_write_loads_out, aclk, aresetn, write_fire, m_valid)

endmodule

/* rtl/core/otmt_cell.sv */
module otmt_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  otmt_pkg::cell_ctrl_t ctrl,
    input  otmt_pkg::entry_t    shift_in,
    input  otmt_pkg::entry_t    wr_data,
    output otmt_pkg::entry_t    q
);

    otmt_pkg::entry_t entry_reg;
    otmt_pkg::entry_t entry_next;

    // shift along the ring, or take a write, or drop the valid bit
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.shift_en) begin
            entry_next = shift_in;
        end else if (ctrl.wr_en) begin
            entry_next = wr_data;
        end else if (ctrl.kill) begin
            entry_next.valid = 1'b0;
        end
        // reset clears only the valid bit
        if (!aresetn) begin
            entry_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam int DEPTH = 32;
    localparam logic [7:0] REG_UNUSED = 8'd8;
    localparam logic [7:0] REG_TOP = 8'd255;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    otmt_pkg::obs_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    otmt_pkg::obs_out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    obstacle_track_merge_table u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // predicted register file
    bit [2:0]  src_mask;
    bit        flt_en, mrg_en, exp_en;
    bit [15:0] max_age;
    bit [14:0] tol_smp, tol_rvl;
    bit [8:0]  beta;

    // predicted obstacle table
    bit        tbl_valid [DEPTH];
    int        tbl_x [DEPTH];
    int        tbl_y [DEPTH];
    bit        tbl_kind [DEPTH];
    bit [31:0] tbl_stamp [DEPTH];

    otmt_pkg::obs_out_t pending_results[$];
    otmt_pkg::obs_out_t chk_exp;
    int        errors = 0;
    int        n_results = 0, n_stored = 0, n_merged = 0, n_ovf = 0;
    int        idle_pct = 0, stall_pct = 0;
    bit [31:0] cur_stamp = 32'd0;
    int        ctr_x [6];
    int        ctr_y [6];

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $time);
        errors++;
    endtask

    function automatic void apply_reg(logic [7:0] idx, logic [31:0] val);
        case (idx)
            otmt_pkg::REG_SOURCE_MASK:   src_mask = val[2:0];
            otmt_pkg::REG_FILTER_ENABLE: flt_en = val[0];
            otmt_pkg::REG_MERGE_ENABLE:  mrg_en = val[0];
            otmt_pkg::REG_EXPIRE_ENABLE: exp_en = val[0];
            otmt_pkg::REG_MAX_AGE_MS:    max_age = val[15:0];
            otmt_pkg::REG_TOL_SAMPLE:    tol_smp = val[14:0];
            otmt_pkg::REG_TOL_RIVAL:     tol_rvl = val[14:0];
            otmt_pkg::REG_BLEND_BETA:    beta = val[8:0];
            default: ;
        endcase
    endfunction

    function automatic int blend_pos(int nv, int ov, int b);
        longint s;
        s = longint'(b) * (nv + 32768) + longint'(256 - b) * (ov + 32768) + 128;
        return int'(s >>> 8) - 32768;
    endfunction

    // expected result of one observation; updates the predicted table
    function automatic otmt_pkg::obs_out_t predict_obs(otmt_pkg::obs_in_t o);
        otmt_pkg::obs_out_t r;
        int nx, ny, newest, slot, merged, b;
        bit [31:0] age, best_age, worst;
        longint dx, dy;
        longint unsigned d2, tol2;
        bit hit [DEPTH];
        r = '0;
        if (o.source_id == 2'd3 || !src_mask[o.source_id]) return r;
        nx = $signed(o.pos_x);
        ny = $signed(o.pos_y);
        merged = 0;
        if (flt_en && exp_en)
            for (int i = 0; i < DEPTH; i++)
                if (tbl_valid[i] && (o.stamp_ms - tbl_stamp[i]) > {16'd0, max_age})
                    tbl_valid[i] = 1'b0;
        if (flt_en && mrg_en) begin
            tol2 = o.obstacle_kind ? tol_rvl : tol_smp;
            tol2 = tol2 * tol2;
            newest = -1;
            best_age = 0;
            for (int i = 0; i < DEPTH; i++) begin
                hit[i] = 1'b0;
                if (tbl_valid[i] && tbl_kind[i] == o.obstacle_kind) begin
                    dx = nx - tbl_x[i];
                    dy = ny - tbl_y[i];
                    d2 = dx * dx + dy * dy;
                    if (d2 < tol2) begin
                        age = o.stamp_ms - tbl_stamp[i];
                        hit[i] = 1'b1;
                        if (newest < 0 || age < best_age) begin
                            newest = i;
                            best_age = age;
                        end
                    end
                end
            end
            if (newest >= 0) begin
                b = (beta > 9'd256) ? 256 : int'(beta);
                nx = blend_pos(nx, tbl_x[newest], b);
                ny = blend_pos(ny, tbl_y[newest], b);
                for (int i = 0; i < DEPTH; i++)
                    if (hit[i]) begin
                        tbl_valid[i] = 1'b0;
                        merged++;
                    end
            end
        end
        slot = -1;
        for (int i = 0; i < DEPTH; i++)
            if (!tbl_valid[i] && slot < 0) slot = i;
        if (slot < 0) begin
            worst = 0;
            slot = 0;
            for (int i = 0; i < DEPTH; i++) begin
                age = o.stamp_ms - tbl_stamp[i];
                if (i == 0 || age > worst) begin
                    worst = age;
                    slot = i;
                end
            end
            r.overflow = 1'b1;
        end
        tbl_valid[slot] = 1'b1;
        tbl_x[slot] = nx;
        tbl_y[slot] = ny;
        tbl_kind[slot] = o.obstacle_kind;
        tbl_stamp[slot] = o.stamp_ms;
        r.accepted = 1'b1;
        r.stored_x = nx[15:0];
        r.stored_y = ny[15:0];
        r.slot = slot[4:0];
        r.merged_count = (merged > 63) ? 6'd63 : merged[5:0];
        return r;
    endfunction

    // send one observation item, with optional idle cycles before it
    task automatic send_obs(otmt_pkg::obs_in_t o);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= o;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.insert(pending_results.size(), predict_obs(o));
    endtask

    function automatic otmt_pkg::obs_in_t make_obs(int x, int y, bit kind, bit [1:0] src,
                                                   bit [31:0] stamp);
        otmt_pkg::obs_in_t o;
        o.pos_x = x[15:0];
        o.pos_y = y[15:0];
        o.obstacle_kind = kind;
        o.source_id = src;
        o.stamp_ms = stamp;
        return o;
    endfunction

    // stop sending, wait for all results and for the block to settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (45) @(posedge aclk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        apply_reg(idx, val);
    endtask

    // receiver back-pressure
    always @(posedge aclk) m_ready <= ($urandom_range(99) >= stall_pct);

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                report("unexpected result item", 1, 0);
            end else begin
                chk_exp = pending_results.pop_front();
                if (m_data.accepted !== chk_exp.accepted)
                    report("accepted", m_data.accepted, chk_exp.accepted);
                if (m_data.stored_x !== chk_exp.stored_x)
                    report("stored_x", m_data.stored_x, chk_exp.stored_x);
                if (m_data.stored_y !== chk_exp.stored_y)
                    report("stored_y", m_data.stored_y, chk_exp.stored_y);
                if (m_data.slot !== chk_exp.slot)
                    report("slot", m_data.slot, chk_exp.slot);
                if (m_data.merged_count !== chk_exp.merged_count)
                    report("merged_count", m_data.merged_count, chk_exp.merged_count);
                if (m_data.overflow !== chk_exp.overflow)
                    report("overflow", m_data.overflow, chk_exp.overflow);
                n_stored += chk_exp.accepted;
                n_merged += (chk_exp.merged_count != 0);
                n_ovf += chk_exp.overflow;
            end
        end
    end

    // dropped items (disabled sources, unnamed source id), unused indexes
    task automatic test_drop();
        send_obs(make_obs(100, 100, 1'b0, 2'd0, 32'd10));
        send_obs(make_obs(100, 100, 1'b1, 2'd3, 32'd10));
        write_reg(otmt_pkg::REG_SOURCE_MASK, 32'hFFFF_FFFA);
        send_obs(make_obs(-32768, 32767, 1'b0, 2'd0, 32'd20));
        send_obs(make_obs(32767, -32768, 1'b1, 2'd2, 32'd20));
        send_obs(make_obs(0, 0, 1'b0, 2'd1, 32'd20));
        send_obs(make_obs(0, 0, 1'b0, 2'd3, 32'd20));
        write_reg(otmt_pkg::REG_SOURCE_MASK, 32'd7);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        write_reg(REG_TOP, 32'd0);
    endtask

    // merging, tolerance extremes and blend weights
    task automatic test_merge();
        write_reg(otmt_pkg::REG_FILTER_ENABLE, 32'hFFFF_FFFF);
        write_reg(otmt_pkg::REG_MERGE_ENABLE, 32'd1);
        write_reg(otmt_pkg::REG_TOL_SAMPLE, 32'hFFFF_FFFF);
        write_reg(otmt_pkg::REG_TOL_RIVAL, 32'd0);
        write_reg(otmt_pkg::REG_BLEND_BETA, 32'd0);
        send_obs(make_obs(-32768, -32768, 1'b0, 2'd0, 32'd30));
        send_obs(make_obs(-32700, -32000, 1'b0, 2'd1, 32'd31));
        write_reg(otmt_pkg::REG_BLEND_BETA, 32'd256);
        send_obs(make_obs(-32000, -32768, 1'b0, 2'd2, 32'd31));
        write_reg(otmt_pkg::REG_BLEND_BETA, 32'd511);
        send_obs(make_obs(-31000, -31000, 1'b0, 2'd0, 32'd40));
        // rival kind with zero tolerance never merges
        send_obs(make_obs(500, 500, 1'b1, 2'd0, 32'd41));
        send_obs(make_obs(500, 500, 1'b1, 2'd0, 32'd42));
        write_reg(otmt_pkg::REG_BLEND_BETA, 32'd77);
        write_reg(otmt_pkg::REG_TOL_RIVAL, 32'd32767);
        send_obs(make_obs(32767, 32767, 1'b1, 2'd1, 32'd50));
    endtask

    // expiry: zero and max age, stamp wrap, a later-stamped entry
    task automatic test_expiry();
        write_reg(otmt_pkg::REG_MERGE_ENABLE, 32'd0);
        write_reg(otmt_pkg::REG_EXPIRE_ENABLE, 32'd1);
        write_reg(otmt_pkg::REG_MAX_AGE_MS, 32'hFFFF_FFFF);
        send_obs(make_obs(10, 10, 1'b0, 2'd0, 32'hFFFF_FFF0));
        send_obs(make_obs(20, 20, 1'b1, 2'd0, 32'h0000_0010));
        send_obs(make_obs(30, 30, 1'b0, 2'd0, 32'h0000_0005));
        write_reg(otmt_pkg::REG_MAX_AGE_MS, 32'd0);
        send_obs(make_obs(40, 40, 1'b0, 2'd2, 32'h0000_0010));
        send_obs(make_obs(50, 50, 1'b0, 2'd2, 32'h0000_0011));
        write_reg(otmt_pkg::REG_MAX_AGE_MS, 32'd1000);
        write_reg(otmt_pkg::REG_FILTER_ENABLE, 32'd0);
    endtask

    function automatic otmt_pkg::obs_in_t rand_obs();
        otmt_pkg::obs_in_t o;
        int c, spread;
        o = '0;
        o.obstacle_kind = $urandom_range(1);
        o.source_id = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
        if ($urandom_range(99) < 75) begin
            // clustered around a few tracks, stamps moving forward
            c = $urandom_range(5);
            spread = ($urandom_range(3) == 0) ? 3000 : 400;
            o.pos_x = 16'(ctr_x[c] + $urandom_range(2 * spread) - spread);
            o.pos_y = 16'(ctr_y[c] + $urandom_range(2 * spread) - spread);
            cur_stamp += $urandom_range(400);
            o.stamp_ms = cur_stamp;
        end else begin
            o.pos_x = 16'($urandom);
            o.pos_y = 16'($urandom);
            o.stamp_ms = ($urandom_range(1) == 0) ? $urandom : cur_stamp - $urandom_range(3000);
        end
        return o;
    endfunction

    function automatic logic [31:0] pick3(logic [31:0] lo, logic [31:0] hi,
                                          logic [31:0] mid);
        case ($urandom_range(3))
            0: return lo;
            1: return hi;
            default: return mid;
        endcase
    endfunction

    // random phases, each with its own idle mix and two register settings
    task automatic test_random();
        int idle_tab [4] = '{0, 81, 0, 29};
        int stall_tab [4] = '{0, 0, 81, 29};
        for (int p = 0; p < 4; p++) begin
            for (int s = 0; s < 2; s++) begin
                idle_pct = 0;
                stall_pct = 0;
                write_reg(otmt_pkg::REG_SOURCE_MASK,
                          ($urandom_range(2) == 0) ? $urandom : 32'd7);
                write_reg(otmt_pkg::REG_FILTER_ENABLE, 32'($urandom_range(4) != 0));
                write_reg(otmt_pkg::REG_MERGE_ENABLE, 32'($urandom_range(3) != 0));
                write_reg(otmt_pkg::REG_EXPIRE_ENABLE, $urandom_range(1));
                write_reg(otmt_pkg::REG_MAX_AGE_MS,
                          pick3(0, 65535, $urandom_range(3000, 200)));
                write_reg(otmt_pkg::REG_TOL_SAMPLE,
                          pick3(0, 32767, $urandom_range(2000, 100)));
                write_reg(otmt_pkg::REG_TOL_RIVAL,
                          pick3(0, 32767, $urandom_range(2000, 100)));
                write_reg(otmt_pkg::REG_BLEND_BETA, pick3(0, 511, $urandom_range(256)));
                for (int c = 0; c < 6; c++) begin
                    ctr_x[c] = $urandom_range(65535) - 32768;
                    ctr_y[c] = $urandom_range(65535) - 32768;
                end
                if ($urandom_range(3) == 0) cur_stamp = 32'hFFFF_F000;
                idle_pct = idle_tab[p];
                stall_pct = stall_tab[p];
                for (int n = 0; n < 150; n++) send_obs(rand_obs());
            end
        end
        idle_pct = 0;
        stall_pct = 0;
        drain();
    endtask

    initial begin
        src_mask = 0; flt_en = 0; mrg_en = 0; exp_en = 0;
        max_age = 16'd1000; tol_smp = 15'd410; tol_rvl = 15'd410; beta = 9'd128;
        for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_drop();
        test_merge();
        test_expiry();
        test_random();
        $display("covered %0d results: %0d stored, %0d merges, %0d overflows",
                 n_results, n_stored, n_merged, n_ovf);
        $display("idle mixes: none, sender idle, receiver stall, both; %0d mismatches",
                 errors);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("[obstacle_track_merge_table] OK");
        end else begin
            $display("[obstacle_track_merge_table] ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("[obstacle_track_merge_table] ERROR");
        $finish;
    end

endmodule
